// ----- hdl/grle_pkg.sv -----
// Shared constants, types and helper functions for the grid reference letter encoder.
package grle_pkg;

   localparam int unsigned EastWidth    = 30;
   localparam int unsigned NorthWidth   = 31;
   localparam int unsigned PrecWidth    = 5;
   localparam int unsigned DigitWidth   = 27;
   localparam int unsigned LetterWidth  = 7;
   localparam int unsigned PadWidth     = 4;
   localparam int unsigned RecipWidth   = 28;
   localparam int unsigned ProductWidth = DigitWidth + RecipWidth;

   // One 100 km square and the largest coordinates that are still encoded, in millimetres.
   localparam logic [31:0] SquareMm   = 32'd100000000;
   localparam logic [31:0] MaxEastMm  = 32'd700000000;
   localparam logic [31:0] MaxNorthMm = 32'd1300000000;

   localparam int unsigned EastSquares  = 7;
   localparam int unsigned NorthSquares = 13;

   localparam logic [4:0] MaxPrecision = 5'd16;
   localparam logic [6:0] LetterA      = 7'd65;
   localparam logic [4:0] LetterIIndex = 5'd8;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_BAD_PRECISION = 2'd1,
      STATUS_OUT_OF_RANGE  = 2'd2
   } status_type;

   // Reciprocal of 10^k for an exact quotient of any 27-bit value:
   // q = (r * M) >> S with S = 27 + ceil(log2(10^k)) and M = ceil(2^S / 10^k).
   function automatic logic [RecipWidth-1:0] recip_mult(input logic [2:0] k);
      logic [RecipWidth-1:0] m;
      begin
         case (k)
            3'd0:    m = 28'd134217728;
            3'd1:    m = 28'd214748365;
            3'd2:    m = 28'd171798692;
            3'd3:    m = 28'd137438954;
            3'd4:    m = 28'd219902326;
            3'd5:    m = 28'd175921861;
            3'd6:    m = 28'd140737489;
            3'd7:    m = 28'd225179982;
            default: m = 28'd134217728;
         endcase
         return m;
      end
   endfunction

   function automatic logic [5:0] recip_shift(input logic [2:0] k);
      logic [5:0] s;
      begin
         case (k)
            3'd0:    s = 6'd27;
            3'd1:    s = 6'd31;
            3'd2:    s = 6'd34;
            3'd3:    s = 6'd37;
            3'd4:    s = 6'd41;
            3'd5:    s = 6'd44;
            3'd6:    s = 6'd47;
            3'd7:    s = 6'd51;
            default: s = 6'd27;
         endcase
         return s;
      end
   endfunction

   // Letter index to ASCII, stepping over the letter I.
   function automatic logic [LetterWidth-1:0] letter_code(input logic [4:0] idx);
      logic [4:0] adj;
      begin
         adj = (idx >= LetterIIndex) ? idx + 5'd1 : idx;
         return LetterA + LetterWidth'(adj);
      end
   endfunction

endpackage

// ----- hdl/grle_if.sv -----
// Request and response channel interfaces of the grid reference letter encoder.
interface grle_req_if import grle_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [EastWidth-1:0]  easting_mm;
   logic [NorthWidth-1:0] northing_mm;
   logic [PrecWidth-1:0]  precision;

   modport source (output valid, output easting_mm, output northing_mm, output precision,
                   input ready);
   modport sink   (input valid, input easting_mm, input northing_mm, input precision,
                   output ready);
endinterface

interface grle_rsp_if import grle_pkg::*; ();
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [LetterWidth-1:0] first_letter;
   logic [LetterWidth-1:0] second_letter;
   logic [DigitWidth-1:0]  east_digits;
   logic [DigitWidth-1:0]  north_digits;
   logic [PadWidth-1:0]    pad_width;

   modport source (output valid, output status, output first_letter, output second_letter,
                   output east_digits, output north_digits, output pad_width,
                   input ready);
   modport sink   (input valid, input status, input first_letter, input second_letter,
                   input east_digits, input north_digits, input pad_width,
                   output ready);
endinterface

// ----- hdl/grid_reference_letter_encode.sv -----
// Top level of the grid reference letter encoder: a four-stage pipeline.
//
// Each request transaction carries an easting and a northing in millimetres and a total
// digit count; each one yields exactly one response transaction, in order. The block is a
// four-stage pipeline that takes one transaction per clock cycle while the response side
// does not stall, passing it through stages one to four in order. Stage one finds the
// 100 km square indices by comparing the coordinates against every square boundary in
// parallel and checks range and precision; stage two forms the offsets within the square
// and the two grid letters; stage three multiplies each offset by a fixed reciprocal of the
// selected power of ten (the widest logic in the design, 27 by 28 bits); stage four shifts
// out the truncated digits and registers the response. Every stage carries its own valid
// bit and loads whenever it is empty or the stage after it moves, so a stalled response
// holds while bubbles further up still fill. Coordinates beyond 700 km east or 1300 km north
// report an out-of-range status, which takes priority over a bad precision (zero, odd or
// above sixteen); any error status comes with all other response fields at zero.
module grid_reference_letter_encode
   import grle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   grle_req_if.sink    req_ch,
   grle_rsp_if.source  rsp_ch
);

   // Stage one: square indices, status and digit scale.
   logic                  s1_valid_ff;
   status_type            s1_status_ff,  s1_status_in;
   logic [EastWidth-1:0]  s1_east_ff;
   logic [NorthWidth-1:0] s1_north_ff;
   logic [2:0]            s1_eq_ff,      s1_eq_in;
   logic [3:0]            s1_nq_ff,      s1_nq_in;
   logic [2:0]            s1_scale_ff,   s1_scale_in;
   logic [PadWidth-1:0]   s1_half_ff,    s1_half_in;

   // Stage two: offsets within the square and the letters.
   logic                   s2_valid_ff;
   status_type             s2_status_ff;
   logic [DigitWidth-1:0]  s2_rem_e_ff,  s2_rem_e_in;
   logic [DigitWidth-1:0]  s2_rem_n_ff,  s2_rem_n_in;
   logic [LetterWidth-1:0] s2_first_ff,  s2_first_in;
   logic [LetterWidth-1:0] s2_second_ff, s2_second_in;
   logic [2:0]             s2_scale_ff;
   logic [PadWidth-1:0]    s2_half_ff;

   // Stage three: reciprocal products.
   logic                    s3_valid_ff;
   status_type              s3_status_ff;
   logic [ProductWidth-1:0] s3_prod_e_ff, s3_prod_e_in;
   logic [ProductWidth-1:0] s3_prod_n_ff, s3_prod_n_in;
   logic [LetterWidth-1:0]  s3_first_ff;
   logic [LetterWidth-1:0]  s3_second_ff;
   logic [2:0]              s3_scale_ff;
   logic [PadWidth-1:0]     s3_half_ff;

   // Stage four: the response register.
   logic                   s4_valid_ff;
   status_type             s4_status_ff, s4_status_in;
   logic [LetterWidth-1:0] s4_first_ff,  s4_first_in;
   logic [LetterWidth-1:0] s4_second_ff, s4_second_in;
   logic [DigitWidth-1:0]  s4_east_ff,   s4_east_in;
   logic [DigitWidth-1:0]  s4_north_ff,  s4_north_in;
   logic [PadWidth-1:0]    s4_pad_ff,    s4_pad_in;

   logic s1_ready, s2_ready, s3_ready, s4_ready;

   // A stage loads when it is empty or its contents move on in the same cycle.
   assign s4_ready = !s4_valid_ff || rsp_ch.ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign req_ch.ready = s1_ready;

   // ---------------------------------------------------------------- stage one
   always_comb begin
      logic [PrecWidth-1:0] prec;
      prec     = req_ch.precision;
      s1_eq_in = 3'd0;
      s1_nq_in = 4'd0;
      // Boundaries are monotonic, so the last one passed gives the square index.
      for (int i = 1; i <= EastSquares; i++) begin
         if (32'(req_ch.easting_mm) >= SquareMm * 32'(i)) begin
            s1_eq_in = 3'(i);
         end
      end
      for (int i = 1; i <= NorthSquares; i++) begin
         if (32'(req_ch.northing_mm) >= SquareMm * 32'(i)) begin
            s1_nq_in = 4'(i);
         end
      end

      s1_half_in  = prec[4:1];
      s1_scale_in = 3'(4'd8 - prec[4:1]);

      if (32'(req_ch.easting_mm) > MaxEastMm || 32'(req_ch.northing_mm) > MaxNorthMm) begin
         s1_status_in = STATUS_OUT_OF_RANGE;
      end else if (prec == 5'd0 || prec[0] || prec > MaxPrecision) begin
         s1_status_in = STATUS_BAD_PRECISION;
      end else begin
         s1_status_in = STATUS_OK;
      end
   end

   // ---------------------------------------------------------------- stage two
   always_comb begin
      logic [4:0] row_base;
      logic [2:0] row_mod;
      logic [1:0] col_step;
      logic [2:0] col_mod;
      logic [4:0] idx_first;
      logic [4:0] idx_second;

      s2_rem_e_in = DigitWidth'(32'(s1_east_ff) - 32'(s1_eq_ff) * SquareMm);
      s2_rem_n_in = DigitWidth'(32'(s1_north_ff) - 32'(s1_nq_ff) * SquareMm);

      // The northern index counts down from the top row of the 500 km grid: the 500 km
      // row and the position within it come from which band of five squares it lies in.
      if (s1_nq_ff < 4'd5) begin
         row_base = 5'd15;
         row_mod  = 3'(4'd4 - s1_nq_ff);
      end else if (s1_nq_ff < 4'd10) begin
         row_base = 5'd10;
         row_mod  = 3'(4'd9 - s1_nq_ff);
      end else begin
         row_base = 5'd5;
         row_mod  = 3'(4'd14 - s1_nq_ff);
      end

      if (s1_eq_ff < 3'd5) begin
         col_step = 2'd2;
         col_mod  = s1_eq_ff;
      end else begin
         col_step = 2'd3;
         col_mod  = s1_eq_ff - 3'd5;
      end

      idx_first    = row_base + 5'(col_step);
      idx_second   = (5'(row_mod) << 2) + 5'(row_mod) + 5'(col_mod);
      s2_first_in  = letter_code(idx_first);
      s2_second_in = letter_code(idx_second);
   end

   // -------------------------------------------------------------- stage three
   always_comb begin
      s3_prod_e_in = ProductWidth'(s2_rem_e_ff) * ProductWidth'(recip_mult(s2_scale_ff));
      s3_prod_n_in = ProductWidth'(s2_rem_n_ff) * ProductWidth'(recip_mult(s2_scale_ff));
   end

   // --------------------------------------------------------------- stage four
   always_comb begin
      logic [5:0] shift;
      shift        = recip_shift(s3_scale_ff);
      s4_status_in = s3_status_ff;
      if (s3_status_ff == STATUS_OK) begin
         s4_first_in  = s3_first_ff;
         s4_second_in = s3_second_ff;
         s4_east_in   = DigitWidth'(s3_prod_e_ff >> shift);
         s4_north_in  = DigitWidth'(s3_prod_n_ff >> shift);
         s4_pad_in    = s3_half_ff;
      end else begin
         s4_first_in  = '0;
         s4_second_in = '0;
         s4_east_in   = '0;
         s4_north_in  = '0;
         s4_pad_in    = '0;
      end
   end

   // ------------------------------------------------------------ valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // ------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_status_ff <= s1_status_in;
         s1_east_ff   <= req_ch.easting_mm;
         s1_north_ff  <= req_ch.northing_mm;
         s1_eq_ff     <= s1_eq_in;
         s1_nq_ff     <= s1_nq_in;
         s1_scale_ff  <= s1_scale_in;
         s1_half_ff   <= s1_half_in;
      end
      if (s2_ready) begin
         s2_status_ff <= s1_status_ff;
         s2_rem_e_ff  <= s2_rem_e_in;
         s2_rem_n_ff  <= s2_rem_n_in;
         s2_first_ff  <= s2_first_in;
         s2_second_ff <= s2_second_in;
         s2_scale_ff  <= s1_scale_ff;
         s2_half_ff   <= s1_half_ff;
      end
      if (s3_ready) begin
         s3_status_ff <= s2_status_ff;
         s3_prod_e_ff <= s3_prod_e_in;
         s3_prod_n_ff <= s3_prod_n_in;
         s3_first_ff  <= s2_first_ff;
         s3_second_ff <= s2_second_ff;
         s3_scale_ff  <= s2_scale_ff;
         s3_half_ff   <= s2_half_ff;
      end
      if (s4_ready) begin
         s4_status_ff <= s4_status_in;
         s4_first_ff  <= s4_first_in;
         s4_second_ff <= s4_second_in;
         s4_east_ff   <= s4_east_in;
         s4_north_ff  <= s4_north_in;
         s4_pad_ff    <= s4_pad_in;
      end
   end

   assign rsp_ch.valid         = s4_valid_ff;
   assign rsp_ch.status        = s4_status_ff;
   assign rsp_ch.first_letter  = s4_first_ff;
   assign rsp_ch.second_letter = s4_second_ff;
   assign rsp_ch.east_digits   = s4_east_ff;
   assign rsp_ch.north_digits  = s4_north_ff;
   assign rsp_ch.pad_width     = s4_pad_ff;

   // ------------------------------------------------------------ assertions

   // An error response carries nothing but its status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STATUS_OK) |->
         (rsp_ch.first_letter == '0 && rsp_ch.second_letter == '0 &&
          rsp_ch.east_digits == '0 && rsp_ch.north_digits == '0 && rsp_ch.pad_width == '0))
      else $error("error response with nonzero fields");

   // A good response has a digit count of one to eight and never the letter I.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_OK) |->
         (rsp_ch.pad_width != '0 && rsp_ch.pad_width <= 4'd8 &&
          rsp_ch.first_letter != LetterA + 7'(LetterIIndex) &&
          rsp_ch.second_letter != LetterA + 7'(LetterIIndex)))
      else $error("good response with bad digit count or letter I");

   // The request side only stalls when every stage holds a transaction.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff))
      else $error("request stalled while the pipeline has a bubble");

   // A response that was not taken is still there in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && !rsp_ch.ready) |=> (s4_valid_ff && $stable(s4_east_ff)))
      else $error("stalled response lost or changed");

endmodule
